// File: sv/fnnf_pkg.sv
`default_nettype none

package fnnf_pkg;

    // Default sizes of the block.
    localparam int MAX_SAMPLES_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int MAX_DIMENSION_DEF = 16;

    // Fixed field widths.
    localparam int DELAY_W   = 8;
    localparam int EXCL_W    = 12;
    localparam int LIM_W     = 16;
    localparam int DIM_IN_W  = 5;
    localparam int SHARE_W   = 16;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // The smallest number of delay vectors that gives an answer.
    localparam int MIN_VECTORS = 2;

    // Register reset values.
    localparam logic [DELAY_W-1:0] DELAY_RST = 8'd1;
    localparam logic [EXCL_W-1:0]  EXCL_RST  = 12'd0;
    localparam logic [LIM_W-1:0]   REL_RST   = 16'd2560;
    localparam logic [LIM_W-1:0]   ABS_RST   = 16'd512;

    // Input item kinds.
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_EVAL   = 1'b1;

    // Register map, indexed by paddr[3:2].
    typedef enum logic [1:0] {
        REG_DELAY = 2'd0,
        REG_EXCL  = 2'd1,
        REG_REL   = 2'd2,
        REG_ABS   = 2'd3
    } fnnf_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_PT_START,
        ST_SCAN,
        ST_DRAIN,
        ST_EXT_RD,
        ST_EXT_DATA,
        ST_EXT_SQ,
        ST_PT_DONE,
        ST_DIV_SET,
        ST_DIV_RUN,
        ST_FINISH
    } fnnf_state_t;

    // Products formed by the shared multiplier.
    typedef enum logic [2:0] {
        OP_NS2,
        OP_SS,
        OP_NN,
        OP_AS,
        OP_RB,
        OP_BS
    } fnnf_op_t;

    // Flags that travel with a coordinate read through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } fnnf_tag_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: sv/fnnf_ram.sv
`default_nettype none

module fnnf_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output      logic [DATA_W-1:0]        rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output      logic [DATA_W-1:0]        rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// File: sv/fnnf_mul.sv
`default_nettype none

module fnnf_mul #(
    parameter int A_W = 64,
    parameter int B_W = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output      logic               done,
    output      logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [A_W-1:0]   hi_reg, hi_next;
    logic [B_W-1:0]   lo_reg, lo_next;
    logic [A_W:0]     step_sum;

    // One multiplier bit per cycle, least significant first.
    assign step_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(B_W);
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end else if (busy_reg) begin
            hi_next  = step_sum[A_W:1];
            lo_next  = {step_sum[0], lo_reg[B_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// File: sv/false_nearest_neighbour_fraction.sv
// False nearest neighbour fraction. Sample beats (kind 0) are taken one per
// cycle and appended to the series store while a running sum and sum of
// squares are kept; first_sample clears the series before its sample, and a
// sample that finds the store full is dropped. An evaluate beat (kind 1)
// gives a dimension m and yields one result beat with the false and valid
// counts, their ratio in Q0.16 and a no-answer flag. During an evaluation
// the input is not ready. An evaluation first forms the setup products on
// the shared multiplier, then for each of the V = N - m*tau vectors runs a
// neighbour scan that skips the excluded neighbours, followed by the
// false-neighbour tests, then divides for the ratio; the multiplier's
// second operand is 32 bits wide at default sizes.
// The scan is set by the series store, which gives one coordinate pair per
// cycle through its two read ports; the tests are set by the shared
// bit-serial multiplier. Results wait in an output register, so new samples
// are taken while a result has not yet been collected.
`default_nettype none

module false_nearest_neighbour_fraction #(
    parameter int MAX_SAMPLES   = fnnf_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS   = fnnf_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_DIMENSION = fnnf_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [fnnf_pkg::APB_AW-1:0]         paddr,
    input  wire logic [fnnf_pkg::APB_DW-1:0]         pwdata,
    output      logic [fnnf_pkg::APB_DW-1:0]         prdata,
    output      logic                                pready,
    // Input channel.
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire logic                                s_kind,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_sample,
    input  wire logic                                s_first_sample,
    input  wire logic [fnnf_pkg::DIM_IN_W-1:0]       s_dimension,
    // Result channel.
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic [$clog2(MAX_SAMPLES+1)-1:0]    m_false_neighbours,
    output      logic [$clog2(MAX_SAMPLES+1)-1:0]    m_valid_points,
    output      logic [fnnf_pkg::SHARE_W-1:0]        m_false_share,
    output      logic                                m_no_answer
);

    import fnnf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS + IDX_W;
    localparam int SQD_W  = 2 * SAMPLE_BITS;
    localparam int D2_W   = SQD_W + DIM_W;
    localparam int SP_W   = SQ_W + CNT_W;
    localparam int NN_W   = 2 * CNT_W;
    localparam int LIM2_W = 2 * LIM_W;
    localparam int MA_W   = max2(max2(SQ_W, SP_W), max2(SUM_W, D2_W + 1));
    localparam int MB_W   = max2(max2(CNT_W, SUM_W), max2(LIM2_W, NN_W));
    localparam int P_W    = MA_W + MB_W;
    localparam int CMP_W  = P_W + SHARE_W;
    localparam int MT_W   = DIM_W + DELAY_W;
    localparam int CW     = max2(CNT_W, MT_W) + 1;
    localparam int EW     = max2(CNT_W, EXCL_W);
    localparam int DC_W   = $clog2(SHARE_W);

    // Control state.
    fnnf_state_t state_reg, state_next;
    fnnf_op_t    op_reg, op_next;
    fnnf_tag_t   p1_reg, p1_next;
    fnnf_tag_t   p2_reg, p2_next;
    logic        m_valid_reg, m_valid_next;

    // Configuration and series statistics.
    logic [DELAY_W-1:0]      delay_reg, delay_next;
    logic [EXCL_W-1:0]       excl_reg, excl_next;
    logic [LIM_W-1:0]        rel_reg, rel_next;
    logic [LIM_W-1:0]        abs_reg, abs_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sqs_reg, sqs_next;

    // Evaluation datapath.
    logic [DIM_W-1:0]  m_reg, m_next;
    logic [MT_W-1:0]   mt_reg, mt_next;
    logic [CNT_W-1:0]  nvec_reg, nvec_next;
    logic [LIM2_W-1:0] rr_reg, rr_next;
    logic [LIM2_W-1:0] aa_reg, aa_next;
    logic [SP_W-1:0]   spread_reg, spread_next;
    logic [NN_W-1:0]   nn1_reg, nn1_next;
    logic [P_W-1:0]    as_reg, as_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [DIM_W-1:0]  d_reg, d_next;
    logic [IDX_W-1:0]  ai_reg, ai_next;
    logic [IDX_W-1:0]  aj_reg, aj_next;
    logic [CNT_W-1:0]  p1_j_reg, p1_j_next;
    logic [CNT_W-1:0]  p2_j_reg, p2_j_next;
    logic [SQD_W-1:0]  sq_reg, sq_next;
    logic [D2_W-1:0]   acc_reg, acc_next;
    logic [D2_W-1:0]   best_reg, best_next;
    logic [CNT_W-1:0]  bestj_reg, bestj_next;
    logic              found_reg, found_next;
    logic [SQD_W-1:0]  ex2_reg, ex2_next;
    logic              relf_reg, relf_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [SHARE_W-1:0] q_reg, q_next;
    logic [DC_W-1:0]   dcnt_reg, dcnt_next;
    logic              none_reg, none_next;

    // Result register.
    logic [CNT_W-1:0]   out_false_reg, out_false_next;
    logic [CNT_W-1:0]   out_valid_reg, out_valid_next;
    logic [SHARE_W-1:0] out_share_reg, out_share_next;
    logic               out_none_reg, out_none_next;

    // Combinational helpers.
    logic                    cfg_wr;
    logic                    app_acc;
    logic                    eval_acc;
    logic [CNT_W-1:0]        base_len;
    logic signed [SUM_W-1:0] base_sum;
    logic [SQ_W-1:0]         base_sqs;
    logic                    store_room;
    logic signed [SQD_W-1:0] samp_w;
    logic [SQD_W-1:0]        samp_sq;
    logic [DIM_W-1:0]        m_clamp;
    logic                    fits;
    logic [CNT_W-1:0]        gap;
    logic                    excluded;
    logic                    last_coord;
    logic                    scan_issue;
    logic [IDX_W-1:0]        rd_addr_a;
    logic [IDX_W-1:0]        rd_addr_b;
    logic [SAMPLE_BITS-1:0]  rd_data_a;
    logic [SAMPLE_BITS-1:0]  rd_data_b;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SQD_W-1:0] diff_w;
    logic [D2_W-1:0]         cand;
    logic [SUM_W-1:0]        abs_sum;
    logic [D2_W:0]           bsum;
    logic                    mul_start;
    logic                    mul_done;
    logic [MA_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [P_W-1:0]          mul_prod;
    logic                    absf;
    logic [CNT_W:0]          rem2;

    // Series store.
    fnnf_ram #(
        .DATA_W (SAMPLE_BITS),
        .DEPTH  (MAX_SAMPLES)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (app_acc && store_room),
        .wr_addr   (IDX_W'(base_len)),
        .wr_data   (s_sample),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // Shared bit-serial multiplier.
    fnnf_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Handshake decode.
    assign cfg_wr   = psel && penable && pwrite;
    assign app_acc  = s_valid && s_ready && (s_kind == KIND_APPEND);
    assign eval_acc = s_valid && s_ready && (s_kind == KIND_EVAL);

    // Append arithmetic.
    assign base_len   = s_first_sample ? '0 : len_reg;
    assign base_sum   = s_first_sample ? '0 : sum_reg;
    assign base_sqs   = s_first_sample ? '0 : sqs_reg;
    assign store_room = (base_len < CNT_W'(MAX_SAMPLES));
    assign samp_w     = SQD_W'(s_sample);
    assign samp_sq    = samp_w * samp_w;

    // Dimension clamp and vector count check.
    always_comb begin
        if (s_dimension == '0) begin
            m_clamp = DIM_W'(1);
        end else if (int'(s_dimension) > MAX_DIMENSION) begin
            m_clamp = DIM_W'(MAX_DIMENSION);
        end else begin
            m_clamp = DIM_W'(s_dimension);
        end
    end

    assign fits = (CW'(len_reg) >= CW'(mt_reg) + CW'(MIN_VECTORS));

    // Neighbour scan helpers.
    assign gap        = (j_reg > i_reg) ? (j_reg - i_reg) : (i_reg - j_reg);
    assign excluded   = (gap == '0) || (EW'(gap) <= EW'(excl_reg));
    assign last_coord = (d_reg == m_reg - DIM_W'(1));
    assign diff       = $signed({rd_data_a[SAMPLE_BITS-1], rd_data_a})
                      - $signed({rd_data_b[SAMPLE_BITS-1], rd_data_b});
    assign diff_w     = SQD_W'(diff);
    assign sq_next    = diff_w * diff_w;
    assign cand       = (p2_reg.first ? '0 : acc_reg) + D2_W'(sq_reg);
    assign abs_sum    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign bsum       = (D2_W+1)'(best_reg) + (D2_W+1)'(ex2_reg);
    assign absf       = {mul_prod, {SHARE_W{1'b0}}} > CMP_W'(as_reg);
    assign rem2       = {rem_reg[CNT_W-1:0], 1'b0};

    // Multiplier operand selection.
    always_comb begin
        case (op_reg)
            OP_NS2: begin
                mul_a = MA_W'(sqs_reg);
                mul_b = MB_W'(len_reg);
            end
            OP_SS: begin
                mul_a = MA_W'(abs_sum);
                mul_b = MB_W'(abs_sum);
            end
            OP_NN: begin
                mul_a = MA_W'(len_reg);
                mul_b = MB_W'(len_reg - CNT_W'(1));
            end
            OP_AS: begin
                mul_a = MA_W'(spread_reg);
                mul_b = MB_W'(aa_reg);
            end
            OP_RB: begin
                mul_a = MA_W'(best_reg);
                mul_b = MB_W'(rr_reg);
            end
            OP_BS: begin
                mul_a = MA_W'(bsum);
                mul_b = MB_W'(nn1_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (eval_acc) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = fits ? ST_MUL_GO : ST_FINISH;
            end
            ST_MUL_GO: begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    case (op_reg)
                        OP_AS:   state_next = ST_PT_START;
                        OP_BS:   state_next = ST_PT_DONE;
                        default: state_next = ST_MUL_GO;
                    endcase
                end
            end
            ST_PT_START: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (j_reg == nvec_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!p1_reg.valid && !p2_reg.valid) begin
                    state_next = ST_EXT_RD;
                end
            end
            ST_EXT_RD: begin
                state_next = found_reg ? ST_EXT_DATA : ST_PT_DONE;
            end
            ST_EXT_DATA: begin
                state_next = ST_EXT_SQ;
            end
            ST_EXT_SQ: begin
                state_next = ST_MUL_GO;
            end
            ST_PT_DONE: begin
                state_next = (i_reg + CNT_W'(1) == nvec_reg) ? ST_DIV_SET : ST_PT_START;
            end
            ST_DIV_SET: begin
                if ((vcnt_reg == '0) || (fcnt_reg == vcnt_reg)) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN: begin
                if (dcnt_reg == DC_W'(SHARE_W - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        mul_start  = (state_reg == ST_MUL_GO);
        scan_issue = (state_reg == ST_SCAN) && (j_reg != nvec_reg)
                  && !((d_reg == '0) && excluded);
        if (state_reg == ST_EXT_RD) begin
            rd_addr_a = IDX_W'(i_reg) + IDX_W'(mt_reg);
            rd_addr_b = IDX_W'(bestj_reg) + IDX_W'(mt_reg);
        end else begin
            rd_addr_a = ai_reg;
            rd_addr_b = aj_reg;
        end
    end

    // Datapath next values.
    always_comb begin
        op_next        = op_reg;
        m_valid_next   = m_valid_reg;
        delay_next     = delay_reg;
        excl_next      = excl_reg;
        rel_next       = rel_reg;
        abs_next       = abs_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        sqs_next       = sqs_reg;
        m_next         = m_reg;
        mt_next        = mt_reg;
        nvec_next      = nvec_reg;
        rr_next        = rr_reg;
        aa_next        = aa_reg;
        spread_next    = spread_reg;
        nn1_next       = nn1_reg;
        as_next        = as_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        d_next         = d_reg;
        ai_next        = ai_reg;
        aj_next        = aj_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        bestj_next     = bestj_reg;
        found_next     = found_reg;
        ex2_next       = ex2_reg;
        relf_next      = relf_reg;
        fcnt_next      = fcnt_reg;
        vcnt_next      = vcnt_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        dcnt_next      = dcnt_reg;
        none_next      = none_reg;
        out_false_next = out_false_reg;
        out_valid_next = out_valid_reg;
        out_share_next = out_share_reg;
        out_none_next  = out_none_reg;

        // Distance pipeline: read, square, accumulate.
        p1_next.valid = scan_issue;
        p1_next.first = (d_reg == '0);
        p1_next.last  = last_coord;
        p1_j_next     = j_reg;
        p2_next       = p1_reg;
        p2_j_next     = p1_j_reg;

        // Configuration writes.
        if (cfg_wr) begin
            case (fnnf_reg_t'(paddr[3:2]))
                REG_DELAY: delay_next = pwdata[DELAY_W-1:0];
                REG_EXCL:  excl_next  = pwdata[EXCL_W-1:0];
                REG_REL:   rel_next   = pwdata[LIM_W-1:0];
                REG_ABS:   abs_next   = pwdata[LIM_W-1:0];
                default:   ;
            endcase
        end

        // Sample beat: optional clear, then append if there is room.
        if (app_acc) begin
            len_next = base_len;
            sum_next = base_sum;
            sqs_next = base_sqs;
            if (store_room) begin
                len_next = base_len + CNT_W'(1);
                sum_next = base_sum + SUM_W'(s_sample);
                sqs_next = base_sqs + SQ_W'(samp_sq);
            end
        end

        // Evaluate beat.
        if (eval_acc) begin
            m_next  = m_clamp;
            mt_next = MT_W'(m_clamp) * MT_W'(delay_reg);
        end

        // The result register empties when its beat is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Accumulate squared distance; pick the nearest at the last coordinate.
        if (p2_reg.valid) begin
            acc_next = cand;
            if (p2_reg.last && (!found_reg || (cand < best_reg))) begin
                best_next  = cand;
                bestj_next = p2_j_reg;
                found_next = 1'b1;
            end
        end

        case (state_reg)
            ST_CHECK: begin
                if (fits) begin
                    nvec_next = CNT_W'(CW'(len_reg) - CW'(mt_reg));
                    rr_next   = LIM2_W'(rel_reg) * LIM2_W'(rel_reg);
                    aa_next   = LIM2_W'(abs_reg) * LIM2_W'(abs_reg);
                    op_next   = OP_NS2;
                end else begin
                    fcnt_next = '0;
                    vcnt_next = '0;
                    q_next    = '0;
                    none_next = 1'b1;
                end
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    case (op_reg)
                        OP_NS2: begin
                            spread_next = SP_W'(mul_prod);
                            op_next     = OP_SS;
                        end
                        OP_SS: begin
                            // Spread is N*S2 - S^2, floored at zero.
                            if (P_W'(spread_reg) >= mul_prod) begin
                                spread_next = SP_W'(P_W'(spread_reg) - mul_prod);
                            end else begin
                                spread_next = '0;
                            end
                            op_next = OP_NN;
                        end
                        OP_NN: begin
                            nn1_next = NN_W'(mul_prod);
                            op_next  = OP_AS;
                        end
                        OP_AS: begin
                            as_next   = mul_prod;
                            i_next    = '0;
                            fcnt_next = '0;
                            vcnt_next = '0;
                            op_next   = OP_RB;
                        end
                        OP_RB: begin
                            // Coincident vectors are false when the extra
                            // coordinate still differs.
                            if (best_reg == '0) begin
                                relf_next = (ex2_reg != '0);
                            end else begin
                                relf_next = ((CMP_W'(ex2_reg) << SHARE_W) > CMP_W'(mul_prod));
                            end
                            op_next = OP_BS;
                        end
                        OP_BS: begin
                            vcnt_next = vcnt_reg + CNT_W'(1);
                            if (relf_reg || absf) begin
                                fcnt_next = fcnt_reg + CNT_W'(1);
                            end
                            op_next = OP_RB;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PT_START: begin
                j_next     = '0;
                d_next     = '0;
                ai_next    = IDX_W'(i_reg);
                aj_next    = '0;
                found_next = 1'b0;
            end
            ST_SCAN: begin
                if (j_reg != nvec_reg) begin
                    if ((d_reg == '0) && excluded) begin
                        j_next  = j_reg + CNT_W'(1);
                        aj_next = IDX_W'(j_reg + CNT_W'(1));
                    end else if (last_coord) begin
                        d_next  = '0;
                        j_next  = j_reg + CNT_W'(1);
                        ai_next = IDX_W'(i_reg);
                        aj_next = IDX_W'(j_reg + CNT_W'(1));
                    end else begin
                        d_next  = d_reg + DIM_W'(1);
                        ai_next = ai_reg + IDX_W'(delay_reg);
                        aj_next = aj_reg + IDX_W'(delay_reg);
                    end
                end
            end
            ST_EXT_SQ: begin
                ex2_next = sq_reg;
            end
            ST_PT_DONE: begin
                i_next = i_reg + CNT_W'(1);
            end
            ST_DIV_SET: begin
                if (vcnt_reg == '0) begin
                    none_next = 1'b1;
                    q_next    = '0;
                end else if (fcnt_reg == vcnt_reg) begin
                    // A share of one saturates.
                    none_next = 1'b0;
                    q_next    = '1;
                end else begin
                    none_next = 1'b0;
                    rem_next  = (CNT_W+1)'(fcnt_reg);
                    q_next    = '0;
                    dcnt_next = '0;
                end
            end
            ST_DIV_RUN: begin
                // Restoring division, one quotient bit per cycle.
                if (rem2 >= (CNT_W+1)'(vcnt_reg)) begin
                    rem_next = rem2 - (CNT_W+1)'(vcnt_reg);
                    q_next   = {q_reg[SHARE_W-2:0], 1'b1};
                end else begin
                    rem_next = rem2;
                    q_next   = {q_reg[SHARE_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DC_W'(1);
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_false_next = fcnt_reg;
                    out_valid_next = vcnt_reg;
                    out_share_next = q_reg;
                    out_none_next  = none_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p1_reg      <= '0;
            p2_reg      <= '0;
            m_valid_reg <= 1'b0;
            delay_reg   <= DELAY_RST;
            excl_reg    <= EXCL_RST;
            rel_reg     <= REL_RST;
            abs_reg     <= ABS_RST;
            len_reg     <= '0;
            sum_reg     <= '0;
            sqs_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            m_valid_reg <= m_valid_next;
            delay_reg   <= delay_next;
            excl_reg    <= excl_next;
            rel_reg     <= rel_next;
            abs_reg     <= abs_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            sqs_reg     <= sqs_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        m_reg         <= m_next;
        mt_reg        <= mt_next;
        nvec_reg      <= nvec_next;
        rr_reg        <= rr_next;
        aa_reg        <= aa_next;
        spread_reg    <= spread_next;
        nn1_reg       <= nn1_next;
        as_reg        <= as_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        d_reg         <= d_next;
        ai_reg        <= ai_next;
        aj_reg        <= aj_next;
        p1_j_reg      <= p1_j_next;
        p2_j_reg      <= p2_j_next;
        sq_reg        <= sq_next;
        acc_reg       <= acc_next;
        best_reg      <= best_next;
        bestj_reg     <= bestj_next;
        found_reg     <= found_next;
        ex2_reg       <= ex2_next;
        relf_reg      <= relf_next;
        fcnt_reg      <= fcnt_next;
        vcnt_reg      <= vcnt_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        dcnt_reg      <= dcnt_next;
        none_reg      <= none_next;
        out_false_reg <= out_false_next;
        out_valid_reg <= out_valid_next;
        out_share_reg <= out_share_next;
        out_none_reg  <= out_none_next;
    end

    // Register read-back.
    always_comb begin
        case (fnnf_reg_t'(paddr[3:2]))
            REG_DELAY: prdata = APB_DW'(delay_reg);
            REG_EXCL:  prdata = APB_DW'(excl_reg);
            REG_REL:   prdata = APB_DW'(rel_reg);
            REG_ABS:   prdata = APB_DW'(abs_reg);
            default:   prdata = '0;
        endcase
    end

    assign pready             = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_false_neighbours = out_false_reg;
    assign m_valid_points     = out_valid_reg;
    assign m_false_share      = out_share_reg;
    assign m_no_answer        = out_none_reg;

endmodule

`default_nettype wire

// File: verif/fnnf_checker.sv
`default_nettype none

module fnnf_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_kind,
    input  wire logic [15:0] s_sample,
    input  wire logic        s_first_sample,
    input  wire logic [4:0]  s_dimension,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [12:0] m_false_neighbours,
    input  wire logic [12:0] m_valid_points,
    input  wire logic [15:0] m_false_share,
    input  wire logic        m_no_answer,
    output int               error_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import fnnf_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int DIM_LIMIT   = 16;

    typedef struct packed {
        logic [12:0] false_neighbours;
        logic [12:0] valid_points;
        logic [15:0] false_share;
        logic        no_answer;
    } fnnf_result_t;

    // Shadow of the block's state and registers.
    logic signed [15:0] series [STORE_DEPTH];
    int                 series_len;
    longint             sum_x;
    longint unsigned    sum_xx;
    logic [7:0]         tau;
    logic [11:0]        window;
    logic [15:0]        rtol;
    logic [15:0]        atol;

    fnnf_result_t pending_results [$];

    assign outstanding = pending_results.size();

    function automatic longint sample_at(int idx);
        if (idx < 0 || idx >= series_len) return 0;
        return longint'(series[idx]);
    endfunction

    // Counts false neighbours for one embedding dimension.
    function automatic fnnf_result_t evaluate_dimension(logic [4:0] dim_in);
        fnnf_result_t    res;
        int              m;
        int              nvec;
        longint unsigned ns2, s2, spread, scale, rr, aa;
        longint unsigned best, d2, ex2, fcount, vcount, share;
        longint          df, ex;
        int              bestj, gap;
        bit              found, judged_false;
        logic [127:0]    lhs, rhs;
        m = (dim_in < 1) ? 1 : (dim_in > DIM_LIMIT) ? DIM_LIMIT : int'(dim_in);
        nvec = series_len - m * int'(tau);
        fcount = 0;
        vcount = 0;
        if (nvec >= MIN_VECTORS) begin
            ns2 = longint'(series_len) * sum_xx;
            s2 = sum_x * sum_x;
            spread = (ns2 >= s2) ? ns2 - s2 : 0;
            scale = 64'd65536 * longint'(series_len) * longint'(series_len - 1);
            rr = rtol * rtol;
            aa = atol * atol;
            for (int i = 0; i < nvec; i++) begin
                found = 0;
                best = 0;
                bestj = 0;
                for (int j = 0; j < nvec; j++) begin
                    gap = (j > i) ? j - i : i - j;
                    if (gap == 0 || gap <= int'(window)) continue;
                    d2 = 0;
                    for (int d = 0; d < m; d++) begin
                        df = sample_at(i + d * tau) - sample_at(j + d * tau);
                        d2 += df * df;
                    end
                    if (!found || d2 < best) begin
                        best = d2;
                        bestj = j;
                        found = 1;
                    end
                end
                if (!found) continue;
                vcount++;
                ex = sample_at(i + m * tau) - sample_at(bestj + m * tau);
                ex2 = ex * ex;
                judged_false = 0;
                // Relative growth test; coincident neighbours are false if they split.
                if (best > 0) begin
                    lhs = 128'(ex2) * 128'(65536);
                    rhs = 128'(rr) * 128'(best);
                    if (lhs > rhs) judged_false = 1;
                end else if (ex != 0) begin
                    judged_false = 1;
                end
                // Absolute test against the series variance, cross-multiplied.
                lhs = 128'(best + ex2) * 128'(scale);
                rhs = 128'(aa) * 128'(spread);
                if (lhs > rhs) judged_false = 1;
                if (judged_false) fcount++;
            end
        end
        res.no_answer = (nvec < MIN_VECTORS) || (vcount == 0);
        share = 0;
        if (!res.no_answer) begin
            share = (fcount * 65536) / vcount;
            if (share > 65535) share = 65535;
        end
        res.false_neighbours = fcount[12:0];
        res.valid_points = vcount[12:0];
        res.false_share = share[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    initial error_count = 0;

    // Track register writes and input beats, and check result beats.
    always @(posedge aclk) begin
        fnnf_result_t want;
        longint       v;
        if (!aresetn) begin
            series_len <= 0;
            sum_x <= 0;
            sum_xx <= 0;
            tau <= DELAY_RST;
            window <= EXCL_RST;
            rtol <= REL_RST;
            atol <= ABS_RST;
            pending_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (fnnf_reg_t'(paddr[3:2]))
                    REG_DELAY: tau <= pwdata[7:0];
                    REG_EXCL:  window <= pwdata[11:0];
                    REG_REL:   rtol <= pwdata[15:0];
                    REG_ABS:   atol <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_kind == KIND_EVAL) begin
                    pending_results.push_back(evaluate_dimension(s_dimension));
                end else begin
                    v = longint'(signed'(s_sample));
                    if (s_first_sample) begin
                        if (STORE_DEPTH > 0) series[0] = s_sample;
                        series_len <= 1;
                        sum_x <= v;
                        sum_xx <= v * v;
                    end else if (series_len < STORE_DEPTH) begin
                        series[series_len] = s_sample;
                        series_len <= series_len + 1;
                        sum_x <= sum_x + v;
                        sum_xx <= sum_xx + v * v;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("[%0t] result beat with nothing expected", $realtime);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_false_neighbours != want.false_neighbours)
                        report_mismatch("false_neighbours", m_false_neighbours,
                                        want.false_neighbours);
                    if (m_valid_points != want.valid_points)
                        report_mismatch("valid_points", m_valid_points, want.valid_points);
                    if (m_false_share != want.false_share)
                        report_mismatch("false_share", m_false_share, want.false_share);
                    if (m_no_answer != want.no_answer)
                        report_mismatch("no_answer", m_no_answer, want.no_answer);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fnnf_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready, s_kind, s_first_sample;
    logic signed [15:0] s_sample;
    logic [4:0]  s_dimension;
    logic        m_valid, m_ready;
    logic [12:0] m_false_neighbours, m_valid_points;
    logic [15:0] m_false_share;
    logic        m_no_answer;
    int          error_count, outstanding;
    int          items_sent;
    bit          steady;

    false_nearest_neighbour_fraction DUT (.*);

    fnnf_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Result side stalls at random except during the steady stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 18);
        end
    end

    // Sends one beat, with a random gap before it, and returns after acceptance.
    task automatic send_beat(logic kind, logic [15:0] value, logic first, logic [4:0] dim);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 18) gap = $urandom_range(4, 1);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_kind <= kind;
        s_sample <= value;
        s_first_sample <= first;
        s_dimension <= dim;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic push_sample(logic [15:0] value, logic first);
        send_beat(KIND_APPEND, value, first, 5'($urandom));
    endtask

    task automatic evaluate(logic [4:0] dim, logic first);
        send_beat(KIND_EVAL, 16'($urandom), first, dim);
    endtask

    // Waits until every result is in and the block has gone quiet.
    task automatic settle();
        s_valid <= 0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(fnnf_reg_t which, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic load_series(int count, int spread_kind);
        logic [15:0] v;
        for (int k = 0; k < count; k++) begin
            case (spread_kind)
                0: v = 16'($urandom);
                1: v = 16'($urandom_range(8)) - 16'd4;
                default: v = 16'($urandom_range(200)) - 16'd100;
            endcase
            push_sample(v, k == 0);
        end
    endtask

    task automatic random_config();
        case ($urandom_range(3))
            0: write_reg(REG_DELAY, $urandom_range(3, 1));
            1: write_reg(REG_EXCL, ($urandom_range(15) == 0) ? 4095 : $urandom_range(6));
            2: write_reg(REG_REL, ($urandom_range(4) == 0) ? 65535 : $urandom_range(4000));
            default: write_reg(REG_ABS, ($urandom_range(4) == 0) ? 0 : $urandom_range(65535));
        endcase
    endtask

    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [4:0] dim;
        aresetn = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        s_valid = 0;
        s_kind = 0;
        s_sample = 0;
        s_first_sample = 0;
        s_dimension = 0;
        items_sent = 0;
        steady = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Empty series, dimension clamped at both ends.
        evaluate(5'd0, 1'b1);
        evaluate(5'd31, 1'b0);
        // Constant series, then a series with the extreme values.
        for (int k = 0; k < 8; k++) push_sample(16'sd5, k == 0);
        evaluate(5'd1, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hffff, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b0);
        evaluate(5'd2, 1'b1);
        settle();
        // Zero delay, and an exclusion window that leaves no neighbour.
        write_reg(REG_DELAY, 0);
        evaluate(5'd3, 1'b0);
        settle();
        write_reg(REG_DELAY, 1);
        write_reg(REG_EXCL, 4095);
        evaluate(5'd1, 1'b0);
        settle();
        write_reg(REG_EXCL, 0);
        write_reg(REG_REL, 0);
        write_reg(REG_ABS, 65535);
        evaluate(5'd1, 1'b0);
        settle();
        write_reg(REG_REL, 65535);
        write_reg(REG_ABS, 0);
        evaluate(5'd2, 1'b0);
        settle();

        // Random phases: configure, load a short series, evaluate a few times.
        while (items_sent < 1850) begin
            steady = (items_sent >= 700 && items_sent < 1000);
            if ($urandom_range(3) == 0) begin
                settle();
                random_config();
                if ($urandom_range(7) == 0) write_reg(REG_DELAY, 255);
            end
            load_series($urandom_range(30, 4), $urandom_range(2));
            repeat ($urandom_range(4, 1)) begin
                if ($urandom_range(9) == 0) push_sample(16'($urandom), $urandom_range(30) == 0);
                dim = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(4, 1));
                evaluate(dim, 1'($urandom_range(1)));
            end
        end
        steady = 0;

        // A longer series at the largest dimensions, then a clear on the last sample.
        settle();
        write_reg(REG_DELAY, 1);
        for (int k = 0; k < 60; k++) push_sample(16'($urandom), k == 0);
        evaluate(5'd16, 1'b0);
        evaluate(5'd20, 1'b1);
        push_sample(16'h1234, 1'b1);
        evaluate(5'd16, 1'b0);
        s_valid <= 0;

        do @(negedge aclk); while (outstanding != 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/fnnf_pkg.sv
sv/fnnf_ram.sv
sv/fnnf_mul.sv
sv/false_nearest_neighbour_fraction.sv
verif/fnnf_checker.sv
verif/tb.sv
